// ----- design/rau_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the rational unit.
package rau_pkg;

  // Operand and result widths
  localparam int OPB         = 16;
  localparam int MAG_W       = 2 * OPB;
  localparam int ACT_W       = 3;
  localparam int RES_NUM_W   = 33;
  localparam int RES_DEN_W   = 31;
  localparam int IN_DATA_W   = ((4 * OPB + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RES_NUM_W + RES_DEN_W + 2;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(MAG_W + 1);
  localparam int CALC_W      = (MAG_W + 1 > RES_NUM_W) ? MAG_W + 1 : RES_NUM_W;

  typedef logic [ACT_W-1:0] act_t;

  // Action codes
  localparam act_t ACT_ADD = 3'd0;
  localparam act_t ACT_SUB = 3'd1;
  localparam act_t ACT_MUL = 3'd2;
  localparam act_t ACT_DIV = 3'd3;
  localparam act_t ACT_CMP = 3'd4;

  // Which pair the reduction unit works on
  typedef enum logic [1:0] {
    SRC_A,
    SRC_B,
    SRC_R
  } red_src_t;

  // Which product the multiplier forms
  typedef enum logic [1:0] {
    MUL_AN_BD,
    MUL_AD_BN,
    MUL_AD_BD,
    MUL_AN_BN
  } mul_sel_t;

  typedef struct packed {
    logic     cap;
    logic     red_start;
    logic     red_wb;
    red_src_t red_src;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic arith;
  } dp_sts_t;

endpackage

// ----- design/rau_reduce.sv -----
`timescale 1ns / 1ps
// Shared reduction unit: binary GCD of two magnitudes, then division of both by it.
module rau_reduce (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     narrow,
  input  logic [rau_pkg::MAG_W-1:0] num_in,
  input  logic [rau_pkg::MAG_W-1:0] den_in,
  output logic                     done,
  output logic [rau_pkg::MAG_W-1:0] q_num,
  output logic [rau_pkg::MAG_W-1:0] q_den
);
  import rau_pkg::*;

  localparam int PRE_SHIFT = MAG_W - OPB;

  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_SETUP,
    R_DIV
  } rstate_t;

  rstate_t          st_r;
  logic             done_r;
  logic             narrow_r;
  logic [MAG_W-1:0] x_r, y_r, g_r;
  logic [CNT_W-1:0] k_r, cnt_r;
  logic [MAG_W-1:0] qn_r, qd_r, remn_r, remd_r;

  // GCD step helpers
  logic             xy_ge;
  logic [MAG_W-1:0] gdiff;

  // Division step helpers
  logic [MAG_W:0]   trn, trd, difn, difd;
  logic             gen, ged;
  logic [MAG_W-1:0] remn_nxt, remd_nxt;

  assign xy_ge = (x_r >= y_r);
  assign gdiff = xy_ge ? (x_r - y_r) : (y_r - x_r);

  assign trn      = {remn_r, qn_r[MAG_W-1]};
  assign trd      = {remd_r, qd_r[MAG_W-1]};
  assign difn     = trn - {1'b0, g_r};
  assign difd     = trd - {1'b0, g_r};
  assign gen      = (trn >= {1'b0, g_r});
  assign ged      = (trd >= {1'b0, g_r});
  assign remn_nxt = gen ? difn[MAG_W-1:0] : trn[MAG_W-1:0];
  assign remd_nxt = ged ? difd[MAG_W-1:0] : trd[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        R_IDLE: begin
          if (start) begin
            x_r      <= num_in;
            y_r      <= den_in;
            qn_r     <= num_in;
            qd_r     <= den_in;
            k_r      <= '0;
            narrow_r <= narrow;
            st_r     <= R_GCD;
          end
        end
        R_GCD: begin
          // stop once either side is zero; g is the other side times 2^k
          if (x_r == '0) begin
            g_r  <= y_r << k_r;
            st_r <= R_SETUP;
          end else if (y_r == '0) begin
            g_r  <= x_r << k_r;
            st_r <= R_SETUP;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (xy_ge) begin
            x_r <= gdiff >> 1;
          end else begin
            y_r <= gdiff >> 1;
          end
        end
        R_SETUP: begin
          // skip the division when there is nothing to divide out
          if (g_r <= MAG_W'(1)) begin
            done_r <= 1'b1;
            st_r   <= R_IDLE;
          end else begin
            remn_r <= '0;
            remd_r <= '0;
            if (narrow_r) begin
              qn_r  <= qn_r << PRE_SHIFT;
              qd_r  <= qd_r << PRE_SHIFT;
              cnt_r <= CNT_W'(OPB);
            end else begin
              cnt_r <= CNT_W'(MAG_W);
            end
            st_r <= R_DIV;
          end
        end
        R_DIV: begin
          // one restoring-division bit per cycle on both dividends
          remn_r <= remn_nxt;
          remd_r <= remd_nxt;
          qn_r   <= {qn_r[MAG_W-2:0], gen};
          qd_r   <= {qd_r[MAG_W-2:0], ged};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            done_r <= 1'b1;
            st_r   <= R_IDLE;
          end
        end
        default: begin
          st_r <= R_IDLE;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign q_num = qn_r;
  assign q_den = qd_r;

endmodule

// ----- design/rau_dp.sv -----
`timescale 1ns / 1ps
// Datapath: operand registers, shared multiplier, result forming, reduction unit, output register.
module rau_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rau_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [rau_pkg::ACT_W-1:0]     in_tuser,
  input  rau_pkg::dp_cmd_t              cmd,
  output rau_pkg::dp_sts_t              sts,
  output logic [rau_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tuser
);
  import rau_pkg::*;

  // Field magnitude of a two's complement value
  function automatic logic [OPB-1:0] mag_of(input logic [OPB-1:0] f);
    mag_of = f[OPB-1] ? (~f + 1'b1) : f;
  endfunction

  // Input fields
  logic [OPB-1:0] f_an, f_ad, f_bn, f_bd;
  logic [OPB-1:0] m_an, m_ad, m_bn, m_bd;

  assign f_an = in_tdata[OPB-1:0];
  assign f_ad = in_tdata[2*OPB-1:OPB];
  assign f_bn = in_tdata[3*OPB-1:2*OPB];
  assign f_bd = in_tdata[4*OPB-1:3*OPB];
  assign m_an = mag_of(f_an);
  assign m_ad = mag_of(f_ad);
  assign m_bn = mag_of(f_bn);
  assign m_bd = mag_of(f_bd);

  logic             arith_r, a_neg_r, b_neg_r;
  logic             in_act_sub_r, in_act_mul_r, in_act_div_r;
  logic [OPB-1:0]   an_r, ad_r, bn_r, bd_r;
  logic [MAG_W-1:0] pl_r, pr_r, pd_r, pn_r;
  logic [MAG_W-1:0] rnm_r, rdm_r;
  logic             rsgn_r, less_r, equal_r;
  logic [RES_NUM_W-1:0] out_num_r;
  logic [RES_DEN_W-1:0] out_den_r;
  logic             out_less_r, out_equal_r, out_err_r;

  // Reduction unit hookup
  logic             red_narrow, red_done;
  logic [MAG_W-1:0] red_num, red_den, q_num, q_den;

  always_comb begin
    case (cmd.red_src)
      SRC_A: begin
        red_num    = MAG_W'(an_r);
        red_den    = MAG_W'(ad_r);
        red_narrow = 1'b1;
      end
      SRC_R: begin
        red_num    = rnm_r;
        red_den    = rdm_r;
        red_narrow = 1'b0;
      end
      default: begin
        red_num    = MAG_W'(bn_r);
        red_den    = MAG_W'(bd_r);
        red_narrow = 1'b1;
      end
    endcase
  end

  rau_reduce u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.red_start),
    .narrow (red_narrow),
    .num_in (red_num),
    .den_in (red_den),
    .done   (red_done),
    .q_num  (q_num),
    .q_den  (q_den)
  );

  // Shared multiplier operand select
  logic [OPB-1:0]   mul_a, mul_b;
  logic [MAG_W-1:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      MUL_AN_BD: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
      MUL_AD_BN: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      MUL_AD_BD: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bn_r;
      end
    endcase
  end

  assign prod = MAG_W'(mul_a) * MAG_W'(mul_b);

  // Compare and form the unreduced result from the products
  logic             lhs_neg, rhs_neg, rhs_eff_neg;
  logic             cmp_less, cmp_equal, pl_ge;
  logic [MAG_W-1:0] addsub_mag, f_num, f_den;
  logic             addsub_neg, f_nneg, f_dneg;

  assign lhs_neg   = a_neg_r && (pl_r != '0);
  assign rhs_neg   = b_neg_r && (pr_r != '0);
  assign pl_ge     = (pl_r >= pr_r);
  assign cmp_equal = (lhs_neg == rhs_neg) && (pl_r == pr_r);
  assign cmp_less  = (lhs_neg && !rhs_neg) ||
                     ((lhs_neg == rhs_neg) && !cmp_equal && (lhs_neg == pl_ge));

  always_comb begin
    rhs_eff_neg = (in_act_sub_r) ? (!rhs_neg && (pr_r != '0)) : rhs_neg;
    if (lhs_neg == rhs_eff_neg) begin
      addsub_mag = pl_r + pr_r;
      addsub_neg = lhs_neg;
    end else if (pl_ge) begin
      addsub_mag = pl_r - pr_r;
      addsub_neg = lhs_neg;
    end else begin
      addsub_mag = pr_r - pl_r;
      addsub_neg = rhs_eff_neg;
    end
  end

  always_comb begin
    if (!arith_r) begin
      f_num  = '0;
      f_den  = '0;
      f_nneg = 1'b0;
      f_dneg = 1'b0;
    end else if (in_act_mul_r) begin
      f_num  = pn_r;
      f_den  = pd_r;
      f_nneg = (a_neg_r != b_neg_r) && (pn_r != '0);
      f_dneg = 1'b0;
    end else if (in_act_div_r) begin
      f_num  = pl_r;
      f_den  = pr_r;
      f_nneg = lhs_neg;
      f_dneg = rhs_neg;
    end else begin
      f_num  = addsub_mag;
      f_den  = pd_r;
      f_nneg = addsub_neg && (addsub_mag != '0);
      f_dneg = 1'b0;
    end
  end

  // Signed result value for the output register
  logic              res_neg;
  logic [CALC_W-1:0] res_ext, res_val;

  assign res_neg = rsgn_r && (rnm_r != '0);
  assign res_ext = CALC_W'(rnm_r);
  assign res_val = res_neg ? (~res_ext + 1'b1) : res_ext;

  always_ff @(posedge clk) begin
    // capture operands as sign and magnitude
    if (cmd.cap) begin
      arith_r      <= (in_tuser <= ACT_DIV);
      in_act_sub_r <= (in_tuser == ACT_SUB);
      in_act_mul_r <= (in_tuser == ACT_MUL);
      in_act_div_r <= (in_tuser == ACT_DIV);
      an_r         <= m_an;
      ad_r         <= m_ad;
      bn_r         <= m_bn;
      bd_r         <= m_bd;
      a_neg_r      <= (f_an[OPB-1] ^ f_ad[OPB-1]) && (m_an != '0);
      b_neg_r      <= (f_bn[OPB-1] ^ f_bd[OPB-1]) && (m_bn != '0);
    end
    // write back reduced pairs
    if (cmd.red_wb) begin
      case (cmd.red_src)
        SRC_A: begin
          an_r <= q_num[OPB-1:0];
          ad_r <= q_den[OPB-1:0];
        end
        SRC_R: begin
          rnm_r <= q_num;
          rdm_r <= q_den;
        end
        default: begin
          bn_r <= q_num[OPB-1:0];
          bd_r <= q_den[OPB-1:0];
        end
      endcase
    end
    // hold products
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_AN_BD: pl_r <= prod;
        MUL_AD_BN: pr_r <= prod;
        MUL_AD_BD: pd_r <= prod;
        default:   pn_r <= prod;
      endcase
    end
    if (cmd.form_en) begin
      rnm_r   <= f_num;
      rdm_r   <= f_den;
      rsgn_r  <= f_nneg ^ f_dneg;
      less_r  <= cmp_less;
      equal_r <= cmp_equal;
    end
    // load the output register
    if (cmd.out_load) begin
      out_num_r   <= res_val[RES_NUM_W-1:0];
      out_den_r   <= RES_DEN_W'(rdm_r);
      out_less_r  <= less_r;
      out_equal_r <= equal_r;
      out_err_r   <= arith_r && (rnm_r == '0) && (rdm_r == '0);
    end
  end

  assign sts.red_done = red_done;
  assign sts.arith    = arith_r;

  assign out_tdata = OUT_DATA_W'({out_equal_r, out_less_r, out_den_r, out_num_r});
  assign out_tuser = out_err_r;

endmodule

// ----- design/rau_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences capture, operand reduction, products, forming, result reduction, output.
module rau_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  rau_pkg::dp_sts_t sts,
  output rau_pkg::dp_cmd_t cmd
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_WAIT_A,
    S_RED_B,
    S_WAIT_B,
    S_MUL,
    S_FORM,
    S_RED_R,
    S_WAIT_R,
    S_OUT
  } state_t;

  state_t   state_r, state_nxt;
  mul_sel_t mul_r, mul_nxt;
  logic     out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    mul_nxt       = mul_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.red_src   = SRC_A;
    cmd.mul_sel   = mul_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_RED_A;
        end
      end
      S_RED_A: begin
        cmd.red_start = 1'b1;
        state_nxt     = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (sts.red_done) begin
          cmd.red_wb = 1'b1;
          state_nxt  = S_RED_B;
        end
      end
      S_RED_B: begin
        cmd.red_src   = SRC_B;
        cmd.red_start = 1'b1;
        state_nxt     = S_WAIT_B;
      end
      S_WAIT_B: begin
        cmd.red_src = SRC_B;
        if (sts.red_done) begin
          cmd.red_wb = 1'b1;
          mul_nxt    = MUL_AN_BD;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (mul_r == MUL_AN_BN) begin
          state_nxt = S_FORM;
        end else begin
          mul_nxt = mul_sel_t'(mul_r + 2'd1);
        end
      end
      S_FORM: begin
        cmd.form_en = 1'b1;
        state_nxt   = sts.arith ? S_RED_R : S_OUT;
      end
      S_RED_R: begin
        cmd.red_src   = SRC_R;
        cmd.red_start = 1'b1;
        state_nxt     = S_WAIT_R;
      end
      S_WAIT_R: begin
        cmd.red_src = SRC_R;
        if (sts.red_done) begin
          cmd.red_wb = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        // load only when the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_r       <= MUL_AN_BD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_r       <= mul_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- design/rational_arith_unit.sv -----
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: controller plus datapath.
//
// Input channel in_*: one item carries the action (in_tuser) and the two
// fractions a = a_num/a_den and b = b_num/b_den (in_tdata). Result channel
// out_*: reduced numerator and denominator, less and equal flags (out_tdata)
// and the 0/0 error flag (out_tuser).
// One item is worked on at a time. After acceptance each operand is reduced,
// four 16x16 products are formed on one multiplier, and for add, subtract,
// multiply and divide the result is reduced. Every reduction runs on the one
// shared unit: a binary GCD of one step per cycle (at most twice the input
// width plus one steps) and, when the GCD exceeds one, a restoring division
// of one bit per cycle over the 16-bit operands or the 32-bit result.
// A new item is accepted the cycle after the result enters the output
// register, so the next item starts only once the last one is through.
// Reset clears the controller and the valid flag; no item is pending after
// it. When the receiver stalls, the result holds in the output register while
// the next item is accepted and computed; that one then waits for the slot.
module rational_arith_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // a_num, a_den, b_num, b_den
  input  logic [rau_pkg::IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [rau_pkg::ACT_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // res_num, res_den, less, equal, zero fill
  output logic [rau_pkg::OUT_DATA_W-1:0] out_tdata,
  // error
  output logic                           out_tuser
);
  import rau_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rau_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ----- design/rau_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the rational unit and its bind to the top level.
module rau_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rau_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import rau_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while item in progress");

  // A 0/0 result shows zero numerator and denominator
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[RES_NUM_W+RES_DEN_W-1:0] == '0)
    else $error("error result with nonzero fields");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
